/* hdl/lfb_pkg.sv */
package lfb_pkg;

    typedef struct packed {
        logic [1:0] action;
        logic [3:0] row;
        logic [3:0] column;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } in_t;

    typedef struct packed {
        logic       status;
        logic [7:0] out_green;
        logic [7:0] out_red;
        logic [7:0] out_blue;
        logic       last;
    } out_t;

    localparam logic [1:0] ACT_SET_PIXEL = 2'd0;
    localparam logic [1:0] ACT_SHOW      = 2'd1;
    localparam logic [1:0] ACT_CLEAR     = 2'd2;

    localparam logic [1:0] CFG_WIDTH      = 2'd0;
    localparam logic [1:0] CFG_HEIGHT     = 2'd1;
    localparam logic [1:0] CFG_BRIGHTNESS = 2'd2;

    localparam logic       STATUS_OK    = 1'b0;
    localparam logic       STATUS_RANGE = 1'b1;

    localparam logic [3:0] DIM_LIMIT  = 4'd8;
    localparam logic [8:0] FULL_SCALE = 9'd255;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SHOW = 2'b10
    } state_t;

endpackage

/* hdl/led_frame_buffer_with_brightness.sv */
// set_pixel and clear: one result, registered in the cycle after the transfer; one per cycle unless the output is held.
// show: pixels pass RAM read, multiply, divide/output; one pixel per cycle from the single
//   RAM read port unless the output is held; next item is taken once the last pixel is output.
// Reset: config to width 8, height 8, brightness 0; per-entry valid flops clear at
//   once, so the pixel store reads as zero with no clearing pass.
module led_frame_buffer_with_brightness #(
    parameter int PIXEL_DEPTH = 64,
    parameter int ROW_STRIDE  = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [7:0]         cfg_wdata,
    input  logic               req_valid,
    output logic               req_ready,
    input  lfb_pkg::in_t       req,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output lfb_pkg::out_t      rsp
);

    localparam int AW = (PIXEL_DEPTH > 1) ? $clog2(PIXEL_DEPTH) : 1;
    localparam int CW = $clog2(PIXEL_DEPTH + 1);

    logic [3:0] width_reg;
    logic [3:0] height_reg;
    logic [7:0] bright_reg;

    lfb_pkg::state_t state_reg, state_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [CW-1:0]   n_reg, n_next;
    logic [PIXEL_DEPTH-1:0] vld_reg, vld_next;

    logic v1_reg, last1_reg, ent1_reg;
    logic v2_reg, last2_reg;
    logic out_valid_reg;
    lfb_pkg::out_t out_reg;

    logic        adv, accept, issue, is_last;
    logic [3:0]  wc, hc;
    logic [6:0]  n_raw;
    logic [8:0]  n_full;
    logic [8:0]  idx;
    logic        bad;
    logic [23:0] rdata, pix;
    logic [7:0]  sc_g, sc_r, sc_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 4'd8;
            height_reg <= 4'd8;
            bright_reg <= 8'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lfb_pkg::CFG_WIDTH:      width_reg  <= cfg_wdata[3:0];
                lfb_pkg::CFG_HEIGHT:     height_reg <= cfg_wdata[3:0];
                lfb_pkg::CFG_BRIGHTNESS: bright_reg <= cfg_wdata;
                default:                 ;
            endcase
        end
    end

    always_comb
    begin
        wc     = (width_reg > lfb_pkg::DIM_LIMIT) ? lfb_pkg::DIM_LIMIT : width_reg;
        hc     = (height_reg > lfb_pkg::DIM_LIMIT) ? lfb_pkg::DIM_LIMIT : height_reg;
        n_raw  = 7'(wc) * 7'(hc);
        n_full = (9'(n_raw) > 9'(PIXEL_DEPTH)) ? 9'(PIXEL_DEPTH) : 9'(n_raw);
        idx    = 9'(req.row) * 9'(ROW_STRIDE) + 9'(req.column);
        bad    = (req.column >= wc) || (req.row >= hc) || (idx >= 9'(PIXEL_DEPTH));
    end

    // whole pipeline moves together; stalls only when the output is held
    assign adv       = !out_valid_reg || rsp_ready;
    assign req_ready = (state_reg == lfb_pkg::ST_IDLE) && !v1_reg && !v2_reg && adv;
    assign accept    = req_valid && req_ready;
    assign issue     = (state_reg == lfb_pkg::ST_SHOW) && adv;
    assign is_last   = (CW'(cnt_reg + CW'(1)) == n_reg);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        n_next     = n_reg;
        vld_next   = vld_reg;
        if (accept)
        begin
            case (req.action)
                lfb_pkg::ACT_SET_PIXEL:
                begin
                    if (!bad)
                    begin
                        vld_next[idx[AW-1:0]] = 1'b1;
                    end
                end
                lfb_pkg::ACT_SHOW:
                begin
                    n_next   = CW'(n_full);
                    cnt_next = '0;
                    if (n_full != 9'd0)
                    begin
                        state_next = lfb_pkg::ST_SHOW;
                    end
                end
                lfb_pkg::ACT_CLEAR:
                begin
                    for (int i = 0; i < PIXEL_DEPTH; i++)
                    begin
                        if (9'(i) < n_full)
                        begin
                            vld_next[i] = 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
        else if (issue)
        begin
            cnt_next = CW'(cnt_reg + CW'(1));
            if (is_last)
            begin
                state_next = lfb_pkg::ST_IDLE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lfb_pkg::ST_IDLE;
            cnt_reg       <= '0;
            n_reg         <= '0;
            vld_reg       <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            n_reg     <= n_next;
            vld_reg   <= vld_next;
            if (adv)
            begin
                v1_reg        <= issue;
                v2_reg        <= v1_reg;
                out_valid_reg <= v2_reg || (accept && (req.action == lfb_pkg::ACT_SET_PIXEL
                                                    || req.action == lfb_pkg::ACT_CLEAR));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            last1_reg <= is_last;
            ent1_reg  <= vld_reg[cnt_reg[AW-1:0]];
            last2_reg <= last1_reg;
            if (v2_reg)
            begin
                out_reg <= '{status: lfb_pkg::STATUS_OK, out_green: sc_g, out_red: sc_r,
                             out_blue: sc_b, last: last2_reg};
            end
            else
            begin
                out_reg <= '{status: bad && (req.action == lfb_pkg::ACT_SET_PIXEL),
                             out_green: 8'd0, out_red: 8'd0, out_blue: 8'd0, last: 1'b1};
            end
        end
    end

    // writes happen only at a transfer in idle, reads only while showing: no overlap
    lfb_ram #(
        .WIDTH (24),
        .DEPTH (PIXEL_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (accept && (req.action == lfb_pkg::ACT_SET_PIXEL) && !bad),
        .waddr (idx[AW-1:0]),
        .wdata ({req.red, req.green, req.blue}),
        .re    (issue),
        .raddr (cnt_reg[AW-1:0]),
        .rdata (rdata)
    );

    // never-written or cleared entries read as black
    assign pix = ent1_reg ? rdata : 24'd0;

    lfb_scale u_scale_g (
        .clk        (clk),
        .en         (adv),
        .channel    (pix[15:8]),
        .brightness (bright_reg),
        .scaled     (sc_g)
    );

    lfb_scale u_scale_r (
        .clk        (clk),
        .en         (adv),
        .channel    (pix[23:16]),
        .brightness (bright_reg),
        .scaled     (sc_r)
    );

    lfb_scale u_scale_b (
        .clk        (clk),
        .en         (adv),
        .channel    (pix[7:0]),
        .brightness (bright_reg),
        .scaled     (sc_b)
    );

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule

/* hdl/lfb_ram.sv */
module lfb_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* hdl/lfb_scale.sv */
// One colour channel: floor(channel * brightness / 255).
// Product is registered; the divide by 255 is x>>8 plus one correction step.
module lfb_scale (
    input  logic       clk,
    input  logic       en,
    input  logic [7:0] channel,
    input  logic [7:0] brightness,
    output logic [7:0] scaled
);

    logic [15:0] prod_reg;
    logic [7:0]  quot;
    logic [8:0]  rem;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= 16'(channel) * 16'(brightness);
        end
    end

    // x/256 undershoots x/255 by less than one; remainder stays below 2*255
    always_comb
    begin
        quot   = prod_reg[15:8];
        rem    = {1'b0, prod_reg[7:0]} + {1'b0, quot};
        scaled = (rem >= lfb_pkg::FULL_SCALE) ? 8'(quot + 8'd1) : quot;
    end

endmodule

/* sim/testbench.sv */
`timescale 1ns / 100ps

module testbench;

    localparam int PIXEL_DEPTH   = 64;
    localparam int AW            = $clog2(PIXEL_DEPTH);
    localparam int ROW_STRIDE    = 8;
    localparam int SETTLE_CYCLES = 10;
    localparam int HOLD_CYCLES   = 250;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    logic          clk;
    logic          rst_n;
    logic          cfg_we;
    logic [1:0]    cfg_index;
    logic [7:0]    cfg_wdata;
    logic          req_valid;
    logic          req_ready;
    lfb_pkg::in_t  req;
    logic          rsp_valid;
    logic          rsp_ready;
    lfb_pkg::out_t rsp;

    // local copy of the frame buffer and its settings
    logic [23:0] fb_pixels [PIXEL_DEPTH];
    logic [3:0]  fb_width;
    logic [3:0]  fb_height;
    logic [7:0]  fb_bright;

    lfb_pkg::out_t led_rsp_due[$];
    int   mismatch_count;
    int   burst_left;
    bit   gaps_on;
    bit   hold_out_req;

    led_frame_buffer_with_brightness dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    function automatic logic [3:0] clamp_dim(input logic [3:0] d);
        return (d > lfb_pkg::DIM_LIMIT) ? lfb_pkg::DIM_LIMIT : d;
    endfunction

    function automatic logic [7:0] scale_channel(input logic [7:0] ch);
        logic [15:0] prod;
        prod = 16'(ch) * 16'(fb_bright);
        return 8'(prod / 16'(lfb_pkg::FULL_SCALE));
    endfunction

    function automatic lfb_pkg::in_t led_item(input logic [1:0] a, input logic [3:0] row,
                                              input logic [3:0] col, input logic [7:0] r,
                                              input logic [7:0] g, input logic [7:0] b);
        lfb_pkg::in_t it;
        it.action = a;
        it.row    = row;
        it.column = col;
        it.red    = r;
        it.green  = g;
        it.blue   = b;
        return it;
    endfunction

    function automatic logic [3:0] random_dim();
        if ($urandom_range(0, 9) < 8)
            return 4'($urandom_range(1, 8));
        return ($urandom_range(0, 1) == 0) ? 4'd0 : 4'($urandom_range(9, 15));
    endfunction

    task automatic predict_led_action(input lfb_pkg::in_t it);
        logic [3:0]    w;
        logic [3:0]    h;
        logic [23:0]   c;
        int            idx;
        int            n;
        lfb_pkg::out_t r;
        w = clamp_dim(fb_width);
        h = clamp_dim(fb_height);
        n = int'(w) * int'(h);
        if (n > PIXEL_DEPTH)
            n = PIXEL_DEPTH;
        r = '0;
        r.last = 1'b1;
        case (it.action)
            lfb_pkg::ACT_SET_PIXEL:
            begin
                idx = int'(it.row) * ROW_STRIDE + int'(it.column);
                if (it.column >= w || it.row >= h || idx >= PIXEL_DEPTH)
                    r.status = lfb_pkg::STATUS_RANGE;
                else
                begin
                    r.status = lfb_pkg::STATUS_OK;
                    fb_pixels[AW'(idx)] = {it.red, it.green, it.blue};
                end
                led_rsp_due.push_back(r);
            end
            lfb_pkg::ACT_SHOW:
            begin
                for (int i = 0; i < n; i++)
                begin
                    c = fb_pixels[AW'(i)];
                    r.status    = lfb_pkg::STATUS_OK;
                    r.out_green = scale_channel(c[15:8]);
                    r.out_red   = scale_channel(c[23:16]);
                    r.out_blue  = scale_channel(c[7:0]);
                    r.last      = (i == n - 1);
                    led_rsp_due.push_back(r);
                end
            end
            lfb_pkg::ACT_CLEAR:
            begin
                for (int i = 0; i < n; i++)
                    fb_pixels[AW'(i)] = '0;
                r.status = lfb_pkg::STATUS_OK;
                led_rsp_due.push_back(r);
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    endtask

    task automatic send_action(input lfb_pkg::in_t it);
        int gap;
        req       <= it;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        predict_led_action(it);
        if (gaps_on)
        begin
            if (burst_left == 0)
            begin
                burst_left = int'($urandom_range(1, 12));
                gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 6));
                if (gap > 0)
                begin
                    req_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            burst_left--;
        end
    endtask

    // idle the request side, wait for every owed result, then let the pipe settle
    task automatic drain_results();
        req_valid <= 1'b0;
        while (led_rsp_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(input logic [3:0] w, input logic [3:0] h, input logic [7:0] b);
        cfg_we    <= 1'b1;
        cfg_index <= lfb_pkg::CFG_WIDTH;
        cfg_wdata <= {4'd0, w};
        @(posedge clk);
        fb_width = w;
        cfg_index <= lfb_pkg::CFG_HEIGHT;
        cfg_wdata <= {4'd0, h};
        @(posedge clk);
        fb_height = h;
        cfg_index <= lfb_pkg::CFG_BRIGHTNESS;
        cfg_wdata <= b;
        @(posedge clk);
        fb_bright = b;
        cfg_we <= 1'b0;
    endtask

    task automatic test_reset_frame();
        // store reads as zero and brightness is zero straight out of reset
        send_action(led_item(lfb_pkg::ACT_SHOW, 4'd0, 4'd0, 8'd0, 8'd0, 8'd0));
        drain_results();
    endtask

    task automatic test_colour_extremes();
        set_config(4'd8, 4'd8, 8'd255);
        send_action(led_item(lfb_pkg::ACT_SET_PIXEL, 4'd0, 4'd0, 8'hff, 8'h00, 8'hff));
        send_action(led_item(lfb_pkg::ACT_SET_PIXEL, 4'd0, 4'd1, 8'haa, 8'h55, 8'h0f));
        send_action(led_item(lfb_pkg::ACT_SET_PIXEL, 4'd7, 4'd7, 8'hff, 8'hff, 8'hff));
        send_action(led_item(lfb_pkg::ACT_SET_PIXEL, 4'd0, 4'd8, 8'h11, 8'h22, 8'h33));
        send_action(led_item(lfb_pkg::ACT_SET_PIXEL, 4'd8, 4'd0, 8'h44, 8'h55, 8'h66));
        send_action(led_item(lfb_pkg::ACT_SET_PIXEL, 4'd15, 4'd15, 8'hff, 8'hff, 8'hff));
        send_action(led_item(lfb_pkg::ACT_SHOW, 4'd0, 4'd0, 8'd0, 8'd0, 8'd0));
        send_action(led_item(lfb_pkg::ACT_CLEAR, 4'd0, 4'd0, 8'd0, 8'd0, 8'd0));
        send_action(led_item(lfb_pkg::ACT_SHOW, 4'd0, 4'd0, 8'd0, 8'd0, 8'd0));
        drain_results();
    endtask

    task automatic test_brightness_ends();
        set_config(4'd2, 4'd1, 8'd0);
        send_action(led_item(lfb_pkg::ACT_SET_PIXEL, 4'd0, 4'd1, 8'hff, 8'h80, 8'h01));
        send_action(led_item(lfb_pkg::ACT_SHOW, 4'd0, 4'd0, 8'd0, 8'd0, 8'd0));
        drain_results();
        set_config(4'd2, 4'd1, 8'd254);
        send_action(led_item(lfb_pkg::ACT_SHOW, 4'd0, 4'd0, 8'd0, 8'd0, 8'd0));
        drain_results();
    endtask

    task automatic test_matrix_dims();
        // oversized registers behave as eight
        set_config(4'd15, 4'd15, 8'd255);
        send_action(led_item(lfb_pkg::ACT_SET_PIXEL, 4'd7, 4'd7, 8'h12, 8'h34, 8'h56));
        send_action(led_item(lfb_pkg::ACT_SET_PIXEL, 4'd1, 4'd8, 8'h12, 8'h34, 8'h56));
        send_action(led_item(lfb_pkg::ACT_SHOW, 4'd0, 4'd0, 8'd0, 8'd0, 8'd0));
        drain_results();
        // zero width: nothing is active, show is silent, clear still answers
        set_config(4'd0, 4'd5, 8'd200);
        send_action(led_item(lfb_pkg::ACT_SET_PIXEL, 4'd0, 4'd0, 8'h9c, 8'h63, 8'hc6));
        send_action(led_item(lfb_pkg::ACT_SHOW, 4'd0, 4'd0, 8'd0, 8'd0, 8'd0));
        send_action(led_item(lfb_pkg::ACT_CLEAR, 4'd0, 4'd0, 8'd0, 8'd0, 8'd0));
        send_action(led_item(ACT_UNUSED, 4'd3, 4'd3, 8'hff, 8'hff, 8'hff));
        drain_results();
        set_config(4'd5, 4'd0, 8'd200);
        send_action(led_item(lfb_pkg::ACT_SET_PIXEL, 4'd0, 4'd0, 8'h9c, 8'h63, 8'hc6));
        send_action(led_item(lfb_pkg::ACT_SHOW, 4'd0, 4'd0, 8'd0, 8'd0, 8'd0));
        drain_results();
        // 3x2 clear covers indexes 0..5 only, row one starts at index eight
        set_config(4'd3, 4'd2, 8'd255);
        send_action(led_item(lfb_pkg::ACT_SET_PIXEL, 4'd1, 4'd2, 8'h5a, 8'ha5, 8'h3c));
        send_action(led_item(lfb_pkg::ACT_CLEAR, 4'd0, 4'd0, 8'd0, 8'd0, 8'd0));
        send_action(led_item(lfb_pkg::ACT_SHOW, 4'd0, 4'd0, 8'd0, 8'd0, 8'd0));
        drain_results();
    endtask

    task automatic test_random_frames();
        int           sent;
        int           pick;
        logic [3:0]   w;
        logic [3:0]   h;
        lfb_pkg::in_t it;
        for (int phase = 0; phase < 4; phase++)
        begin
            set_config(random_dim(), random_dim(), 8'($urandom_range(0, 255)));
            w = clamp_dim(fb_width);
            h = clamp_dim(fb_height);
            sent = 0;
            while (sent < 16)
            begin
                pick = int'($urandom_range(0, 99));
                it = led_item(lfb_pkg::ACT_SET_PIXEL, 4'($urandom_range(0, 15)),
                              4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                if (pick < 55)
                begin
                    if (w != 0 && h != 0 && $urandom_range(0, 4) != 0)
                    begin
                        it.row    = 4'($urandom_range(0, h - 1));
                        it.column = 4'($urandom_range(0, w - 1));
                    end
                end
                else if (pick < 72)
                    it.action = lfb_pkg::ACT_SHOW;
                else if (pick < 82)
                    it.action = lfb_pkg::ACT_CLEAR;
                else if (pick < 87)
                    it.action = ACT_UNUSED;
                send_action(it);
                if (it.action != ACT_UNUSED)
                    sent++;
            end
            drain_results();
        end
    endtask

    task automatic test_output_backpressure();
        set_config(4'd8, 4'd8, 8'($urandom_range(1, 255)));
        gaps_on = 1'b0;
        hold_out_req = 1'b1;
        send_action(led_item(lfb_pkg::ACT_SHOW, 4'd0, 4'd0, 8'd0, 8'd0, 8'd0));
        for (int i = 0; i < 24; i++)
            send_action(led_item(lfb_pkg::ACT_SET_PIXEL, 4'($urandom_range(0, 7)),
                                 4'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                                 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))));
        send_action(led_item(lfb_pkg::ACT_SHOW, 4'd0, 4'd0, 8'd0, 8'd0, 8'd0));
        gaps_on = 1'b1;
        drain_results();
    endtask

    // receiver: always-ready, random stalls, a fixed duty pattern, or a forced hold
    initial
    begin : rsp_stall_pattern
        int hold_left;
        int cyc;
        int mode;
        hold_left = 0;
        cyc = 0;
        mode = 0;
        rsp_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            cyc++;
            if (hold_out_req)
            begin
                hold_out_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (cyc % 50 == 0)
                mode = int'($urandom_range(0, 2));
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ready <= 1'b0;
            end
            else
            begin
                case (mode)
                    0:       rsp_ready <= 1'b1;
                    1:       rsp_ready <= ($urandom_range(0, 2) != 0);
                    default: rsp_ready <= ((cyc % 7) < 4);
                endcase
            end
        end
    end

    initial
    begin : led_rsp_checker
        lfb_pkg::out_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_valid && rsp_ready)
            begin
                if (led_rsp_due.size() == 0)
                    report_mismatch("transfer with nothing owed", int'(rsp), 0);
                else
                begin
                    want = led_rsp_due.pop_front();
                    if (rsp.status !== want.status)
                        report_mismatch("status", int'(rsp.status), int'(want.status));
                    if (rsp.out_green !== want.out_green)
                        report_mismatch("out_green", int'(rsp.out_green),
                                        int'(want.out_green));
                    if (rsp.out_red !== want.out_red)
                        report_mismatch("out_red", int'(rsp.out_red), int'(want.out_red));
                    if (rsp.out_blue !== want.out_blue)
                        report_mismatch("out_blue", int'(rsp.out_blue), int'(want.out_blue));
                    if (rsp.last !== want.last)
                        report_mismatch("last", int'(rsp.last), int'(want.last));
                end
            end
        end
    end

    initial
    begin
        mismatch_count = 0;
        burst_left = 0;
        gaps_on = 1'b1;
        hold_out_req = 1'b0;
        fb_width = 4'd8;
        fb_height = 4'd8;
        fb_bright = 8'd0;
        for (int i = 0; i < PIXEL_DEPTH; i++)
            fb_pixels[AW'(i)] = '0;
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= lfb_pkg::CFG_WIDTH;
        cfg_wdata <= 8'd0;
        req_valid <= 1'b0;
        req       <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_frame();
        test_colour_extremes();
        test_brightness_ends();
        test_matrix_dims();
        test_random_frames();
        test_output_backpressure();
        drain_results();

        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
